// File: hw/rtl/fbpa_pkg.sv
// Shared constants, codes and types for the fixed block pool allocator.
`timescale 1ns / 1ps
`default_nettype none

package fbpa_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ADDR_W     = 32;
    localparam int BB_W       = 17;
    localparam int PROD_W     = CNT_W + BB_W;
    localparam int STEP_W     = $clog2(ADDR_W);
    localparam int DATA_W     = 32;
    localparam int PADDR_W    = 4;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_ALLOC = 2'd0;
    localparam cmd_t CMD_FREE  = 2'd1;
    localparam cmd_t CMD_RESET = 2'd2;
    localparam cmd_t CMD_QUERY = 2'd3;

    typedef logic [2:0] status_t;
    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_EMPTY    = 3'd1;
    localparam status_t ST_NULL     = 3'd2;
    localparam status_t ST_RANGE    = 3'd3;
    localparam status_t ST_MISALIGN = 3'd4;
    localparam status_t ST_FULL     = 3'd5;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_POOL_BASE   = 2'd0;
    localparam reg_idx_t REG_BLOCK_BYTES = 2'd1;
    localparam reg_idx_t REG_BLOCK_COUNT = 2'd2;

    localparam logic [BB_W-1:0]  RST_BLOCK_BYTES = 17'd64;
    localparam logic [CNT_W-1:0] RST_BLOCK_COUNT = 11'd1024;

    // Status of the remainder unit toward the sequencer.
    typedef struct packed {
        logic done;
        logic zero;
    } rem_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/fixed_block_pool_allocator_top.sv
// Top level of the fixed block pool allocator: sequencer, free ring and APB registers.
`timescale 1ns / 1ps
`default_nettype none

// Fixed-size block pool allocator. A command is taken when start is high and busy is
// low; its single result appears in the cycle after the last work cycle, for exactly
// one cycle, marked by done, and cannot be held off, so capture it on that cycle.
// Steps from the accepting edge to the done cycle: query goes straight to the report;
// allocate takes one registered ring read plus the base add; free forms the product of
// count and size, does the range compare, runs the bit-serial remainder unit that
// checks alignment, picks up the remainder, then reports (a null address returns
// after the product step, an address outside the pool after the range compare);
// reset pool runs the refill walk, writing one ring entry per cycle for block_count
// entries, limited to 1024. A new command may be taken in the same cycle that done
// is high. After rst_n rises the block runs the same refill walk with the reset
// register values, with busy high; APB writes are taken during that time.
// Registers (pool_base at 0x0, block_bytes at 0x4, block_count at 0x8) take effect
// at once but the free ring is refilled from them only by reset pool or rst_n;
// write them only while the block is idle. Double frees are not detected.

module fixed_block_pool_allocator_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // command channel
    input  wire logic                          start,
    output      logic                          busy,
    input  wire fbpa_pkg::cmd_t                command,
    input  wire logic [fbpa_pkg::ADDR_W-1:0]   address,
    // result channel
    output      logic                          done,
    output      fbpa_pkg::status_t             status,
    output      logic [fbpa_pkg::ADDR_W-1:0]   block_address,
    output      logic [fbpa_pkg::CNT_W-1:0]    free_count,
    output      logic [fbpa_pkg::CNT_W-1:0]    used_count,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fbpa_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [fbpa_pkg::DATA_W-1:0]   pwdata,
    output      logic [fbpa_pkg::DATA_W-1:0]   prdata,
    output      logic                          pready
);
    import fbpa_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_FILL     = 3'd1;
    localparam logic [2:0] S_ALLOC    = 3'd2;
    localparam logic [2:0] S_FREE_MUL = 3'd3;
    localparam logic [2:0] S_FREE_CHK = 3'd4;
    localparam logic [2:0] S_FREE_DIV = 3'd5;
    localparam logic [2:0] S_REPORT   = 3'd6;

    // Control state
    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [ADDR_W-1:0] acc_reg, acc_next;
    logic              report_reg, report_next;
    logic              done_reg, done_next;

    // Configuration registers
    logic [ADDR_W-1:0] pool_base_reg;
    logic [BB_W-1:0]   block_bytes_reg;
    logic [CNT_W-1:0]  block_count_reg;

    // Work and result payload
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    status_t           st_reg, st_next;
    logic [ADDR_W-1:0] baddr_reg, baddr_next;
    status_t           status_reg, status_next;
    logic [ADDR_W-1:0] block_address_reg, block_address_next;
    logic [CNT_W-1:0]  free_count_reg, free_count_next;
    logic [CNT_W-1:0]  used_count_reg, used_count_next;

    // Free ring storage
    logic [ADDR_W-1:0] mem [MAX_BLOCKS];
    logic [ADDR_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [ADDR_W-1:0] mem_wdata;

    logic [CNT_W-1:0]  eff_n;
    logic [ADDR_W-1:0] offset_diff;
    logic [ADDR_W:0]   end_sum;
    logic              out_of_range;
    logic [IDX_W-1:0]  head_inc;
    logic [IDX_W-1:0]  tail_inc;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;
    logic              rem_go;
    rem_status_t       rem_stat;

    // Block count is limited to the ring depth.
    assign eff_n = (block_count_reg > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                           : block_count_reg;

    assign offset_diff  = addr_reg - pool_base_reg;
    assign end_sum      = {1'b0, pool_base_reg} + (ADDR_W + 1)'(prod_reg);
    assign out_of_range = (addr_reg < pool_base_reg) || ({1'b0, addr_reg} >= end_sum);

    assign head_inc = (head_reg == IDX_W'(MAX_BLOCKS - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == IDX_W'(MAX_BLOCKS - 1)) ? '0 : tail_reg + 1'b1;

    // ------------------------------------------------------------------
    // APB register file: pready is tied high, so every access is zero-wait.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_comb
    begin
        unique case (cfg_idx)
            REG_POOL_BASE:   prdata = pool_base_reg;
            REG_BLOCK_BYTES: prdata = DATA_W'(block_bytes_reg);
            REG_BLOCK_COUNT: prdata = DATA_W'(block_count_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg   <= '0;
            block_bytes_reg <= RST_BLOCK_BYTES;
            block_count_reg <= RST_BLOCK_COUNT;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_POOL_BASE:   pool_base_reg   <= pwdata[ADDR_W-1:0];
                REG_BLOCK_BYTES: block_bytes_reg <= pwdata[BB_W-1:0];
                REG_BLOCK_COUNT: block_count_reg <= pwdata[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Remainder unit: (address - base) mod block size, one bit a cycle.
    // ------------------------------------------------------------------
    fbpa_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (rem_go),
        .dividend (offset_diff),
        .divisor  (block_bytes_reg),
        .stat     (rem_stat)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next         = state_reg;
        head_next          = head_reg;
        tail_next          = tail_reg;
        fill_next          = fill_reg;
        idx_next           = idx_reg;
        acc_next           = acc_reg;
        report_next        = report_reg;
        done_next          = 1'b0;
        addr_next          = addr_reg;
        prod_next          = prod_reg;
        st_next            = st_reg;
        baddr_next         = baddr_reg;
        status_next        = status_reg;
        block_address_next = block_address_reg;
        free_count_next    = free_count_reg;
        used_count_next    = used_count_reg;
        mem_we             = 1'b0;
        mem_waddr          = tail_reg;
        mem_wdata          = offset_diff;
        rem_go             = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    addr_next  = address;
                    st_next    = ST_OK;
                    baddr_next = '0;
                    unique case (command)
                        CMD_ALLOC:
                        begin
                            if (fill_reg == '0)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_REPORT;
                            end
                            else
                            begin
                                state_next = S_ALLOC;
                            end
                        end
                        CMD_FREE:
                        begin
                            state_next = S_FREE_MUL;
                        end
                        CMD_RESET:
                        begin
                            idx_next    = '0;
                            acc_next    = '0;
                            report_next = 1'b1;
                            state_next  = S_FILL;
                        end
                        CMD_QUERY:
                        begin
                            state_next = S_REPORT;
                        end
                        default:
                        begin
                            state_next = S_REPORT;
                        end
                    endcase
                end
            end

            // Write offset idx*block_bytes into ring entry idx, one entry a cycle.
            S_FILL:
            begin
                if (idx_reg < eff_n)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg[IDX_W-1:0];
                    mem_wdata = acc_reg;
                    idx_next  = idx_reg + 1'b1;
                    acc_next  = acc_reg + ADDR_W'(block_bytes_reg);
                end
                else
                begin
                    head_next  = '0;
                    tail_next  = (eff_n >= CNT_W'(MAX_BLOCKS)) ? '0 : eff_n[IDX_W-1:0];
                    fill_next  = eff_n;
                    state_next = report_reg ? S_REPORT : S_IDLE;
                end
            end

            // Ring read at the head was registered on the accepting edge.
            S_ALLOC:
            begin
                baddr_next = pool_base_reg + rd_data_reg;
                head_next  = head_inc;
                fill_next  = fill_reg - 1'b1;
                state_next = S_REPORT;
            end

            S_FREE_MUL:
            begin
                prod_next = PROD_W'(eff_n) * PROD_W'(block_bytes_reg);
                if (addr_reg == '0)
                begin
                    st_next    = ST_NULL;
                    state_next = S_REPORT;
                end
                else
                begin
                    state_next = S_FREE_CHK;
                end
            end

            S_FREE_CHK:
            begin
                if (out_of_range)
                begin
                    st_next    = ST_RANGE;
                    state_next = S_REPORT;
                end
                else if (block_bytes_reg == '0)
                begin
                    st_next    = ST_MISALIGN;
                    state_next = S_REPORT;
                end
                else
                begin
                    rem_go     = 1'b1;
                    state_next = S_FREE_DIV;
                end
            end

            // Wait for the remainder, check alignment and ring space, then queue the block.
            S_FREE_DIV:
            begin
                if (rem_stat.done)
                begin
                    state_next = S_REPORT;
                    if (!rem_stat.zero)
                    begin
                        st_next = ST_MISALIGN;
                    end
                    else if (fill_reg >= eff_n)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        tail_next = tail_inc;
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end

            // Load the result registers; done pulses in the next cycle.
            S_REPORT:
            begin
                done_next          = 1'b1;
                status_next        = st_reg;
                block_address_next = baddr_reg;
                free_count_next    = fill_reg;
                used_count_next    = (fill_reg >= eff_n) ? '0 : eff_n - fill_reg;
                state_next         = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Reset starts the refill walk with the reset register values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_FILL;
            head_reg   <= '0;
            tail_reg   <= '0;
            fill_reg   <= '0;
            idx_reg    <= '0;
            acc_reg    <= '0;
            report_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            fill_reg   <= fill_next;
            idx_reg    <= idx_next;
            acc_reg    <= acc_next;
            report_reg <= report_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg          <= addr_next;
        prod_reg          <= prod_next;
        st_reg            <= st_next;
        baddr_reg         <= baddr_next;
        status_reg        <= status_next;
        block_address_reg <= block_address_next;
        free_count_reg    <= free_count_next;
        used_count_reg    <= used_count_next;
    end

    // Ring memory: one write port, one registered read at the head.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[head_reg];
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign block_address = block_address_reg;
    assign free_count    = free_count_reg;
    assign used_count    = used_count_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result transfer without preceding work");

    a_empty_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (free_count == '0 && block_address == '0))
        else $error("pool empty reported with blocks in the ring");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(MAX_BLOCKS))
        else $error("ring fill exceeds ring depth");

    a_rem_launch: assert property (@(posedge clk) disable iff (!rst_n)
        rem_go |=> (state_reg == S_FREE_DIV && !rem_stat.done))
        else $error("remainder unit launched outside the free check");

endmodule

`default_nettype wire

// File: hw/rtl/fbpa_rem_unit.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module fbpa_rem_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       go,
    input  wire logic [fbpa_pkg::ADDR_W-1:0] dividend,
    input  wire logic [fbpa_pkg::BB_W-1:0]   divisor,
    output fbpa_pkg::rem_status_t           stat
);
    import fbpa_pkg::*;

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [ADDR_W-1:0] dq_reg, dq_next;
    logic [BB_W-1:0]   dv_reg, dv_next;
    logic [BB_W-1:0]   rem_reg, rem_next;
    logic [BB_W:0]     shifted;
    logic [BB_W:0]     trial;
    logic              fits;

    // Shift in the next dividend bit and subtract where the divisor fits.
    assign shifted = {rem_reg, dq_reg[ADDR_W-1]};
    assign trial   = shifted - {1'b0, dv_reg};
    assign fits    = shifted >= {1'b0, dv_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        dv_next   = dv_reg;
        rem_next  = rem_reg;
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = STEP_W'(ADDR_W - 1);
            dq_next  = dividend;
            dv_next  = divisor;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            rem_next = fits ? trial[BB_W-1:0] : shifted[BB_W-1:0];
            dq_next  = {dq_reg[ADDR_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        dv_reg  <= dv_next;
        rem_reg <= rem_next;
    end

    assign stat.done = done_reg;
    assign stat.zero = (rem_reg == '0);

endmodule

`default_nettype wire
